/* design/mlpbp_pkg.sv */
// Package for the 2-2-1 sigmoid network training step: sizes, number formats,
// the sigmoid table, the weight reset seeds and the address helpers.
// No dependencies.
package mlpbp_pkg;

    localparam int NUM_INPUTS  = 2;
    localparam int NUM_HIDDEN  = 2;
    localparam int FRAC_BITS   = 12;

    localparam int ONE         = 1 << FRAC_BITS;
    localparam int HID_STRIDE  = NUM_INPUTS + 1;
    localparam int OUT_BASE    = NUM_HIDDEN * HID_STRIDE;
    localparam int STORE_DEPTH = OUT_BASE + NUM_HIDDEN + 1;

    localparam int IN_W        = 16;
    localparam int W_W         = 16;
    localparam int ACT_W       = FRAC_BITS + 1;
    localparam int DELTA_W     = FRAC_BITS;
    localparam int OP_W        = 18;
    localparam int PROD_W      = 2 * OP_W;
    localparam int ACC_W       = 40;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IN_IDX_W    = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int HID_IDX_W   = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
    localparam int SIG_SAT     = 8 << FRAC_BITS;

    typedef logic signed [IN_W-1:0]   t_in;
    typedef logic signed [W_W-1:0]    t_weight;
    typedef logic [ACT_W-1:0]         t_act;
    typedef logic signed [OP_W-1:0]   t_op;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [IN_IDX_W-1:0]      t_in_idx;
    typedef logic [HID_IDX_W-1:0]     t_hid_idx;
    typedef t_weight                  t_seed_tab [STORE_DEPTH];

    // Sigmoid at k/2 for k = 0..16, unsigned with 16 fraction bits.
    function automatic logic [16:0] sig_lut(input logic [4:0] k);
        logic [16:0] v;
        unique case (k)
            5'd0:    v = 17'd32768;
            5'd1:    v = 17'd40793;
            5'd2:    v = 17'd47911;
            5'd3:    v = 17'd53581;
            5'd4:    v = 17'd57725;
            5'd5:    v = 17'd60565;
            5'd6:    v = 17'd62428;
            5'd7:    v = 17'd63615;
            5'd8:    v = 17'd64357;
            5'd9:    v = 17'd64808;
            5'd10:   v = 17'd65097;
            5'd11:   v = 17'd65269;
            5'd12:   v = 17'd65374;
            5'd13:   v = 17'd65438;
            5'd14:   v = 17'd65476;
            5'd15:   v = 17'd65500;
            default: v = 17'd65514;
        endcase
        return v;
    endfunction

    // Reset weights: (((5k+3) mod 17) - 8) sixteenths of one, stepped without a divider.
    function automatic t_seed_tab seed_tab();
        t_seed_tab tab;
        int v;
        v = 3;
        for (int k = 0; k < STORE_DEPTH; k++) begin
            tab[k] = W_W'((v - 8) * (ONE / 16));
            v = v + 5;
            if (v >= 17) begin
                v = v - 17;
            end
        end
        return tab;
    endfunction

    function automatic t_weight sat16(input t_acc v);
        t_weight r;
        if (v > t_acc'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -t_acc'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[W_W-1:0];
        end
        return r;
    endfunction

    function automatic t_addr hid_addr(input t_hid_idx h, input int i);
        return ADDR_W'(int'(h) * HID_STRIDE + i);
    endfunction

endpackage

/* design/mlpbp_if.sv */
// Request and result channel interfaces for the network training step.
// Depends on mlpbp_pkg.
interface mlpbp_in_if;
    logic                        valid;
    logic                        ready;
    logic signed [15:0]          first_input;
    logic signed [15:0]          second_input;
    logic [mlpbp_pkg::ACT_W-1:0] target_value;

    modport source (output valid, first_input, second_input, target_value, input ready);
    modport sink   (input valid, first_input, second_input, target_value, output ready);
endinterface

interface mlpbp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [mlpbp_pkg::ACT_W-1:0]          output_activation;
    logic signed [mlpbp_pkg::DELTA_W-1:0] output_delta;
    logic                                 decision_bit;

    modport source (output valid, output_activation, output_delta, decision_bit,
                    input ready);
    modport sink   (input valid, output_activation, output_delta, decision_bit,
                    output ready);
endinterface

/* design/mlpbp_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mlpbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/mlpbp_wstore.sv */
// Weight store: RAM plus one valid bit per entry, so that an entry not yet
// written since reset reads as its seed value. Depends on mlpbp_pkg, mlpbp_ram.
module mlpbp_wstore (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mlpbp_pkg::t_addr   i_raddr,
    input  logic               i_we,
    input  mlpbp_pkg::t_addr   i_waddr,
    input  mlpbp_pkg::t_weight i_wdata,
    output mlpbp_pkg::t_weight o_rdata
);
    import mlpbp_pkg::*;

    localparam t_seed_tab SEED = seed_tab();

    logic [STORE_DEPTH-1:0] r_valid;
    logic                   r_rvalid;
    t_weight                r_seed;
    logic [W_W-1:0]         ram_rdata;

    mlpbp_ram #(.WIDTH(W_W), .DEPTH(STORE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
        r_seed <= SEED[i_raddr];
    end

    assign o_rdata = r_rvalid ? t_weight'(ram_rdata) : r_seed;
endmodule

/* design/mlpbp_sigmoid.sv */
// Two-stage fixed-point sigmoid: table lookup with linear interpolation.
// Depends on mlpbp_pkg.
module mlpbp_sigmoid (
    input  logic             i_clk,
    input  mlpbp_pkg::t_acc  i_acc,
    output mlpbp_pkg::t_act  o_act
);
    import mlpbp_pkg::*;

    t_acc                 z;
    t_acc                 mag;
    logic                 r_neg;
    logic                 r_sat;
    logic [3:0]           r_idx;
    logic [FRAC_BITS-2:0] r_frac;
    logic [16:0]          lo;
    logic [16:0]          hi;
    logic [16+FRAC_BITS-1:0] ip;
    logic [16:0]          y16;
    logic [17:0]          rnd;
    t_act                 y;
    t_act                 r_act;

    // The input is the unscaled sum; the pre-activation is its floor shift.
    always_comb begin
        z   = i_acc >>> FRAC_BITS;
        mag = z[ACC_W-1] ? -z : z;
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= z[ACC_W-1];
        r_sat  <= mag >= t_acc'(SIG_SAT);
        r_idx  <= mag[FRAC_BITS+2:FRAC_BITS-1];
        r_frac <= mag[FRAC_BITS-2:0];
    end

    always_comb begin
        lo  = sig_lut({1'b0, r_idx});
        hi  = sig_lut(5'({1'b0, r_idx}) + 5'd1);
        ip  = (16+FRAC_BITS)'(hi - lo) * (16+FRAC_BITS)'(r_frac);
        y16 = r_sat ? sig_lut(5'd16) : lo + 17'(ip >> (FRAC_BITS - 1));
        rnd = (18'(y16) + 18'(1 << (15 - FRAC_BITS))) >> (16 - FRAC_BITS);
        y   = rnd[ACT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_act <= r_neg ? t_act'(ONE) - y : y;
    end

    assign o_act = r_act;
endmodule

/* design/mlp_online_backprop_step.sv */
// One online training step of a 2-2-1 sigmoid network per request: forward
// pass, output delta, then a backpropagation update of all nine weights.
// A request is taken only in the idle state, so a new one is not accepted until the result of
// the last is loaded into the result register; the pace is set by the single shared multiplier,
// the registered weight RAM read and the registered sigmoid. An unaccepted result holds the next one back.
// Synchronous active-low reset restores the seed weights at once (per-entry
// valid bits) and empties the result register.
module mlp_online_backprop_step (
    input  logic i_clk,
    input  logic i_rst_n,
    mlpbp_in_if.sink    i_req,
    mlpbp_out_if.source o_rsp
);
    import mlpbp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_HB, S_HB2, S_HM, S_HA, S_OB, S_OB2, S_OM, S_OA,
        S_SG1, S_SG2, S_SG3, S_D1, S_D2, S_D3, S_D4,
        S_BW, S_BW2, S_BW3, S_BW4, S_BW5, S_BW6, S_BW7,
        S_HU, S_HW, S_HBU, S_OBU, S_FIN
    } t_state;

    t_state   r_state;
    t_in      r_x [NUM_INPUTS];
    t_act     r_t;
    t_act     r_hact [NUM_HIDDEN];
    t_act     r_s;
    t_in_idx  r_i;
    t_hid_idx r_h;
    logic     r_olayer;
    t_acc     r_acc;
    t_prod    r_prod;
    t_op      r_slope, r_delta, r_back, r_hslope, r_dh;
    t_weight  r_wq;
    logic     r_ov;
    t_act     r_o_act;
    logic signed [DELTA_W-1:0] r_o_delta;
    logic     r_o_dec;

    t_addr    raddr, waddr;
    logic     we;
    t_weight  wdata, rdata;
    t_act     sig_y;
    t_op      ma, mb;
    t_op      hact_op, s_op, t_op_v, x_op, rd_op;
    logic     last_i, last_h;

    mlpbp_wstore u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (raddr),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    mlpbp_sigmoid u_sig (
        .i_clk (i_clk),
        .i_acc (r_acc),
        .o_act (sig_y)
    );

    always_comb begin
        last_i  = r_i == IN_IDX_W'(NUM_INPUTS - 1);
        last_h  = r_h == HID_IDX_W'(NUM_HIDDEN - 1);
        hact_op = OP_W'(signed'({1'b0, r_hact[r_h]}));
        s_op    = OP_W'(signed'({1'b0, r_s}));
        t_op_v  = OP_W'(signed'({1'b0, r_t}));
        x_op    = OP_W'(r_x[r_i]);
        rd_op   = OP_W'(rdata);
    end

    // Read address for the state that follows; write port for the update states.
    always_comb begin
        raddr = '0;
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        case (r_state)
            S_HB:  raddr = hid_addr(r_h, NUM_INPUTS);
            S_HB2: raddr = hid_addr(r_h, 0);
            S_HA:  raddr = hid_addr(r_h, int'(r_i) + 1);
            S_OB:  raddr = ADDR_W'(OUT_BASE + NUM_HIDDEN);
            S_OB2: raddr = ADDR_W'(OUT_BASE);
            S_OA:  raddr = ADDR_W'(OUT_BASE + int'(r_h) + 1);
            S_BW:  raddr = ADDR_W'(OUT_BASE + int'(r_h));
            S_BW7: raddr = hid_addr(r_h, 0);
            S_HW: begin
                raddr = last_i ? hid_addr(r_h, NUM_INPUTS) : hid_addr(r_h, int'(r_i) + 1);
                we    = 1'b1;
                waddr = hid_addr(r_h, int'(r_i));
                wdata = sat16(ACC_W'(r_wq) + ACC_W'(r_prod >>> FRAC_BITS));
            end
            S_BW4: begin
                we    = 1'b1;
                waddr = ADDR_W'(OUT_BASE + int'(r_h));
                wdata = sat16(ACC_W'(r_wq) + ACC_W'(r_prod >>> FRAC_BITS));
            end
            S_HBU: begin
                raddr = ADDR_W'(OUT_BASE + NUM_HIDDEN);
                we    = 1'b1;
                waddr = hid_addr(r_h, NUM_INPUTS);
                wdata = sat16(ACC_W'(rdata) + ACC_W'(r_dh));
            end
            S_OBU: begin
                we    = 1'b1;
                waddr = ADDR_W'(OUT_BASE + NUM_HIDDEN);
                wdata = sat16(ACC_W'(rdata) + ACC_W'(r_delta));
            end
            default: ;
        endcase
    end

    // Operands of the shared multiplier.
    always_comb begin
        ma = '0;
        mb = '0;
        case (r_state)
            S_HM:  begin ma = x_op;     mb = rd_op;                end
            S_OM:  begin ma = hact_op;  mb = rd_op;                end
            S_D1:  begin ma = s_op;     mb = OP_W'(ONE) - s_op;    end
            S_D3:  begin ma = r_slope;  mb = t_op_v - s_op;        end
            S_BW2: begin ma = r_delta;  mb = rd_op;                end
            S_BW3: begin ma = r_delta;  mb = hact_op;              end
            S_BW4: begin ma = hact_op;  mb = OP_W'(ONE) - hact_op; end
            S_BW6: begin ma = r_hslope; mb = r_back;               end
            S_HU:  begin ma = r_dh;     mb = x_op;                 end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(ma) * PROD_W'(mb);
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (o_rsp.ready && r_state != S_FIN) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_x[0] <= i_req.first_input;
                        r_x[1] <= i_req.second_input;
                        // Targets above one are saturated to one.
                        r_t    <= (i_req.target_value > t_act'(ONE)) ? t_act'(ONE)
                                                                     : i_req.target_value;
                        r_h    <= '0;
                        r_olayer <= 1'b0;
                        r_state  <= S_HB;
                    end
                end
                S_HB:  r_state <= S_HB2;
                S_HB2: begin
                    r_acc   <= ACC_W'(rdata) <<< FRAC_BITS;
                    r_i     <= '0;
                    r_state <= S_HM;
                end
                S_HM:  r_state <= S_HA;
                S_HA: begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                    if (last_i) begin
                        r_state <= S_SG1;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_HM;
                    end
                end
                S_OB:  r_state <= S_OB2;
                S_OB2: begin
                    r_acc   <= ACC_W'(rdata) <<< FRAC_BITS;
                    r_h     <= '0;
                    r_state <= S_OM;
                end
                S_OM:  r_state <= S_OA;
                S_OA: begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                    if (last_h) begin
                        r_olayer <= 1'b1;
                        r_state  <= S_SG1;
                    end else begin
                        r_h     <= r_h + 1'b1;
                        r_state <= S_OM;
                    end
                end
                S_SG1: r_state <= S_SG2;
                S_SG2: r_state <= S_SG3;
                S_SG3: begin
                    if (r_olayer) begin
                        r_s     <= sig_y;
                        r_state <= S_D1;
                    end else begin
                        r_hact[r_h] <= sig_y;
                        if (last_h) begin
                            r_state <= S_OB;
                        end else begin
                            r_h     <= r_h + 1'b1;
                            r_state <= S_HB;
                        end
                    end
                end
                S_D1:  r_state <= S_D2;
                S_D2: begin
                    r_slope <= OP_W'(r_prod >>> FRAC_BITS);
                    r_state <= S_D3;
                end
                S_D3:  r_state <= S_D4;
                S_D4: begin
                    r_delta <= OP_W'(r_prod >>> FRAC_BITS);
                    r_h     <= '0;
                    r_state <= S_BW;
                end
                // The output weight is read before it is rewritten, so the hidden
                // delta sees the value from before this step.
                S_BW:  r_state <= S_BW2;
                S_BW2: begin
                    r_wq    <= rdata;
                    r_state <= S_BW3;
                end
                S_BW3: begin
                    r_back  <= OP_W'(r_prod >>> FRAC_BITS);
                    r_state <= S_BW4;
                end
                S_BW4: r_state <= S_BW5;
                S_BW5: begin
                    r_hslope <= OP_W'(r_prod >>> FRAC_BITS);
                    r_state  <= S_BW6;
                end
                S_BW6: r_state <= S_BW7;
                S_BW7: begin
                    r_dh    <= OP_W'(r_prod >>> FRAC_BITS);
                    r_i     <= '0;
                    r_state <= S_HU;
                end
                S_HU: begin
                    r_wq    <= rdata;
                    r_state <= S_HW;
                end
                S_HW: begin
                    if (last_i) begin
                        r_state <= S_HBU;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_HU;
                    end
                end
                S_HBU: begin
                    if (last_h) begin
                        r_state <= S_OBU;
                    end else begin
                        r_h     <= r_h + 1'b1;
                        r_state <= S_BW;
                    end
                end
                S_OBU: r_state <= S_FIN;
                S_FIN: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ov      <= 1'b1;
                        r_o_act   <= r_s;
                        r_o_delta <= r_delta[DELTA_W-1:0];
                        r_o_dec   <= ((ACT_W+3)'(r_s) << 2) + (ACT_W+3)'(r_s)
                                     > (ACT_W+3)'(ONE);
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready             = r_state == S_IDLE;
    assign o_rsp.valid             = r_ov;
    assign o_rsp.output_activation = r_o_act;
    assign o_rsp.output_delta      = r_o_delta;
    assign o_rsp.decision_bit      = r_o_dec;
endmodule

/* tb/tb_top.sv */
// Self-checking bench for mlp_online_backprop_step: random and directed training samples,
// a scoreboard that predicts every result from its own copy of the weights.
// Depends on mlpbp_pkg, mlpbp_in_if, mlpbp_out_if and mlp_online_backprop_step.
`timescale 1ns / 1ps

class backprop_scoreboard;
    typedef struct {
        logic [12:0] act;
        logic [11:0] delta;
        logic        dec;
    } step_result_t;

    mlpbp_pkg::t_weight weights [9];
    step_result_t       expected_q [$];
    int                 mismatches;

    function new();
        for (int k = 0; k < 9; k++) begin
            weights[k] = 16'(((((5 * k) + 3) % 17) - 8) * 256);
        end
        mismatches = 0;
    endfunction

    function longint clip16(longint v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function longint squash(longint z);
        longint slope_tab [17] = '{32768, 40793, 47911, 53581, 57725, 60565, 62428, 63615,
                                   64357, 64808, 65097, 65269, 65374, 65438, 65476, 65500,
                                   65514};
        longint mag, y16, y, idx, lo;
        if (z > (64'sd1 <<< 30)) begin
            z = 64'sd1 <<< 30;
        end else if (z < -(64'sd1 <<< 30)) begin
            z = -(64'sd1 <<< 30);
        end
        mag = (z < 0) ? -z : z;
        if (mag >= (8 << 12)) begin
            y16 = slope_tab[16];
        end else begin
            idx = mag >>> 11;
            lo  = slope_tab[idx];
            y16 = lo + (((slope_tab[idx + 1] - lo) * (mag & 2047)) >>> 11);
        end
        y = (y16 + 8) >>> 4;
        return (z < 0) ? 4096 - y : y;
    endfunction

    // Runs the forward pass and the weight update for one accepted request.
    function void note_request(longint x0, longint x1, longint tgt);
        longint x [2];
        longint hact [2];
        longint w_old [2];
        longint acc, s, slope, d_out, back, hslope, dh;
        step_result_t r;
        x[0] = x0;
        x[1] = x1;
        if (tgt > 4096) begin
            tgt = 4096;
        end
        for (int h = 0; h < 2; h++) begin
            acc = longint'(weights[h * 3 + 2]) * 4096;
            for (int i = 0; i < 2; i++) begin
                acc += x[i] * longint'(weights[h * 3 + i]);
            end
            hact[h] = squash(acc >>> 12);
        end
        acc = longint'(weights[8]) * 4096;
        for (int h = 0; h < 2; h++) begin
            acc += hact[h] * longint'(weights[6 + h]);
        end
        s     = squash(acc >>> 12);
        slope = (s * (4096 - s)) >>> 12;
        d_out = (slope * (tgt - s)) >>> 12;
        for (int h = 0; h < 2; h++) begin
            w_old[h]      = weights[6 + h];
            weights[6 + h] = 16'(clip16(w_old[h] + ((d_out * hact[h]) >>> 12)));
        end
        weights[8] = 16'(clip16(longint'(weights[8]) + d_out));
        for (int h = 0; h < 2; h++) begin
            back   = (d_out * w_old[h]) >>> 12;
            hslope = (hact[h] * (4096 - hact[h])) >>> 12;
            dh     = (hslope * back) >>> 12;
            for (int i = 0; i < 2; i++) begin
                weights[h * 3 + i] = 16'(clip16(longint'(weights[h * 3 + i])
                                                + ((dh * x[i]) >>> 12)));
            end
            weights[h * 3 + 2] = 16'(clip16(longint'(weights[h * 3 + 2]) + dh));
        end
        r.act   = 13'(s);
        r.delta = 12'(d_out);
        r.dec   = (5 * s > 4096);
        expected_q.push_back(r);
    endfunction

    function void check_result(logic [12:0] act, logic [11:0] delta, logic dec);
        step_result_t e;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result: act=%0d delta=%0d dec=%0d", act, delta, dec);
            end
            return;
        end
        e = expected_q.pop_front();
        if (act !== e.act || delta !== e.delta || dec !== e.dec) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result wrong: act %0d/%0d delta %0d/%0d dec %0d/%0d (exp/got)",
                         e.act, act, $signed(e.delta), $signed(delta), e.dec, dec);
            end
        end
    endfunction
endclass

module tb_top;
    logic clk;
    logic rst_n;
    logic quiet;
    int   idle_cycles;

    mlpbp_in_if  req_if ();
    mlpbp_out_if rsp_if ();
    backprop_scoreboard sb;

    mlp_online_backprop_step dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    task automatic send_request(logic [15:0] x0, logic [15:0] x1, logic [12:0] tgt);
        int g;
        req_if.valid        <= 1'b1;
        req_if.first_input  <= x0;
        req_if.second_input <= x1;
        req_if.target_value <= tgt;
        do @(posedge clk); while (!req_if.ready);
        g = gap_len();
        if (g > 0) begin
            req_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Result side: random stalls, none while the quiet stretch runs.
    initial begin
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            if (gap_len() > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (req_if.valid && req_if.ready) begin
                sb.note_request($signed(req_if.first_input), $signed(req_if.second_input),
                                req_if.target_value);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                sb.check_result(rsp_if.output_activation, rsp_if.output_delta,
                                rsp_if.decision_bit);
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= 5000) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        logic [15:0] dir_x0 [20] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                                     16'h1000, 16'hF000, 16'h0001, 16'hFFFF, 16'h7FFF,
                                     16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                                     16'h8000, 16'h0800, 16'h5555, 16'hAAAA, 16'h0000};
        logic [15:0] dir_x1 [20] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                                     16'h1000, 16'h1000, 16'hFFFF, 16'h0001, 16'h7FFF,
                                     16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                                     16'h8000, 16'hF800, 16'hAAAA, 16'h5555, 16'h0000};
        logic [12:0] dir_t  [20] = '{13'd0, 13'd4096, 13'd0, 13'd8191, 13'd4097,
                                     13'd4096, 13'd0, 13'd2048, 13'd819, 13'd0,
                                     13'd0, 13'd0, 13'd0, 13'd4096, 13'd4096,
                                     13'd4096, 13'd1000, 13'h0AAA, 13'h1555, 13'd820};
        int r;
        sb          = new();
        quiet       = 1'b0;
        idle_cycles = 0;
        rst_n       <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.first_input  <= '0;
        req_if.second_input <= '0;
        req_if.target_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes first; the repeated full-scale samples drive weights into saturation.
        for (int k = 0; k < 20; k++) begin
            send_request(dir_x0[k], dir_x1[k], dir_t[k]);
        end

        for (int n = 0; n < 750; n++) begin
            quiet = (n >= 200 && n < 280);
            if (n == 400) begin
                req_if.valid <= 1'b0;
                // Waiting on the clock first lets the monitor log the last accepted request.
                @(posedge clk);
                while (sb.expected_q.size() != 0) @(posedge clk);
            end
            r = $urandom_range(0, 9);
            if (r < 7) begin
                send_request(16'($urandom_range(0, 16383) - 8192),
                             16'($urandom_range(0, 16383) - 8192),
                             13'($urandom_range(0, 4096)));
            end else if (r < 9) begin
                send_request(16'($urandom), 16'($urandom), 13'($urandom_range(0, 8191)));
            end else begin
                send_request($urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                             $urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                             $urandom_range(0, 1) ? 13'd4096 : 13'd0);
            end
        end
        req_if.valid <= 1'b0;
        @(posedge clk);

        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* sim.f */
design/mlpbp_pkg.sv
design/mlpbp_if.sv
design/mlpbp_ram.sv
design/mlpbp_wstore.sv
design/mlpbp_sigmoid.sv
design/mlp_online_backprop_step.sv
tb/tb_top.sv
